// ===== sv/iwd_pkg.sv =====
package iwd_pkg;

  typedef struct packed {
    logic [13:0] calendar_year;
    logic [3:0]  calendar_month;
    logic [4:0]  calendar_day;
  } date_in_t;

  typedef struct packed {
    logic [13:0] week_year;
    logic [5:0]  week_number;
  } week_out_t;

  typedef struct packed {
    logic [13:0] year;
    logic [14:0] yr_ofs;
    logic [7:0]  cent_ofs;
    logic [8:0]  ord;
    logic        leap_cur;
    logic        leap_prev;
  } yr_info_t;

  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  ord;
    logic        leap_cur;
    logic        leap_prev;
    logic [8:0]  wd_sum;
    logic [5:0]  wd_quot;
  } wd_info_t;

  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam logic [15:0] DIV7_MUL_WIDE = 16'd37450;
  localparam logic [13:0] DIV7_MUL = 14'd9363;
  localparam logic [14:0] YEAR_OFS = 15'd399;

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/iwd_year.sv =====
module iwd_year import iwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  date_in_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output yr_info_t out_data
);

  logic        v1_r, v2_r;
  logic        en1, en2;
  logic [13:0] year1_r;
  logic [3:0]  month1_r;
  logic [4:0]  day1_r;
  logic [14:0] yofs1_r;
  logic [7:0]  q100y1_r;
  logic [3:0]  month_nxt;
  logic [26:0] prod_y;
  logic [27:0] prod_p;
  logic [13:0] r100_full;
  logic [6:0]  r100;
  logic [6:0]  r100_prev;
  logic [7:0]  q100_prev;
  logic [13:0] year_prev;
  yr_info_t    info_nxt;
  yr_info_t    info2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    if (in_data.calendar_month == 4'd0) begin
      month_nxt = 4'd1;
    end else if (in_data.calendar_month > 4'd12) begin
      month_nxt = 4'd12;
    end else begin
      month_nxt = in_data.calendar_month;
    end
    prod_y = in_data.calendar_year * DIV100_MUL;
  end

  always_comb begin
    r100_full = year1_r - 14'(q100y1_r) * 14'd100;
    r100      = r100_full[6:0];
    r100_prev = (r100 == 7'd0) ? 7'd99 : r100 - 7'd1;
    q100_prev = (r100 == 7'd0) ? q100y1_r - 8'd1 : q100y1_r;
    year_prev = year1_r - 14'd1;
    prod_p    = yofs1_r * DIV100_MUL;

    info_nxt.year      = year1_r;
    info_nxt.yr_ofs    = yofs1_r;
    info_nxt.cent_ofs  = prod_p[26:19];
    info_nxt.leap_cur  = (year1_r[1:0] == 2'b00)
                         && ((r100 != 7'd0) || (q100y1_r[1:0] == 2'b00));
    info_nxt.leap_prev = (year_prev[1:0] == 2'b00)
                         && ((r100_prev != 7'd0) || (q100_prev[1:0] == 2'b00));
    info_nxt.ord       = days_before_month(month1_r)
                         + 9'((info_nxt.leap_cur && (month1_r > 4'd2)) ? 1 : 0)
                         + 9'(day1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      year1_r  <= in_data.calendar_year;
      month1_r <= month_nxt;
      day1_r   <= in_data.calendar_day;
      yofs1_r  <= {1'b0, in_data.calendar_year} + YEAR_OFS;
      q100y1_r <= prod_y[26:19];
    end
    if (en2 && v1_r) begin
      info2_r <= info_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = info2_r;

endmodule

// ===== sv/iwd_wday.sv =====
module iwd_wday import iwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  yr_info_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output wd_info_t out_data
);

  logic        v3_r, v4_r, v5_r, v6_r;
  logic        en3, en4, en5, en6;
  yr_info_t    a3_r, a4_r, a5_r;
  logic [14:0] s3_r, s4_r;
  logic [12:0] q4_r;
  logic [8:0]  x5_r;
  logic [15:0] s_nxt;
  logic [30:0] prod_s;
  logic [14:0] r7_full;
  logic [8:0]  x_nxt;
  logic [22:0] prod_x;
  wd_info_t    o6_r;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  always_comb begin
    s_nxt   = 16'd1 + 16'(in_data.yr_ofs) + 16'(in_data.yr_ofs >> 2)
              - 16'(in_data.cent_ofs) + 16'(in_data.cent_ofs >> 2);
    prod_s  = s3_r * DIV7_MUL_WIDE;
    r7_full = s4_r - 15'(q4_r) * 15'd7;
    x_nxt   = 9'(r7_full[2:0]) + a4_r.ord + 9'd6;
    prod_x  = x5_r * DIV7_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      a3_r <= in_data;
      s3_r <= s_nxt[14:0];
    end
    if (en4 && v3_r) begin
      a4_r <= a3_r;
      s4_r <= s3_r;
      q4_r <= prod_s[30:18];
    end
    if (en5 && v4_r) begin
      a5_r <= a4_r;
      x5_r <= x_nxt;
    end
    if (en6 && v5_r) begin
      o6_r.year      <= a5_r.year;
      o6_r.ord       <= a5_r.ord;
      o6_r.leap_cur  <= a5_r.leap_cur;
      o6_r.leap_prev <= a5_r.leap_prev;
      o6_r.wd_sum    <= x5_r;
      o6_r.wd_quot   <= prod_x[21:16];
    end
  end

  assign out_valid = v6_r;
  assign out_data  = o6_r;

endmodule

// ===== sv/iwd_week.sv =====
module iwd_week import iwd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wd_info_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output week_out_t out_data
);

  logic               v7_r, v8_r;
  logic               en7, en8;
  logic [8:0]         wd_full;
  logic [2:0]         wd;
  logic [2:0]         iso;
  logic signed [10:0] thu;
  logic signed [10:0] len_cur;
  logic signed [10:0] len_prev;
  logic [13:0]        wy_nxt;
  logic [10:0]        tord_nxt;
  logic [13:0]        wy7_r;
  logic [8:0]         tord7_r;
  logic [22:0]        prod_w;
  week_out_t          o8_r;

  assign en8      = !v8_r || out_ready;
  assign en7      = !v7_r || en8;
  assign in_ready = en7;

  always_comb begin
    wd_full  = in_data.wd_sum - 9'(in_data.wd_quot) * 9'd7;
    wd       = wd_full[2:0];
    iso      = (wd == 3'd0) ? 3'd7 : wd;
    thu      = $signed({2'b00, in_data.ord}) + 11'sd4 - $signed({8'd0, iso});
    len_cur  = in_data.leap_cur ? 11'sd366 : 11'sd365;
    len_prev = in_data.leap_prev ? 11'sd366 : 11'sd365;
    if (thu < 11'sd1) begin
      wy_nxt   = in_data.year - 14'd1;
      tord_nxt = 11'(thu + len_prev);
    end else if (thu > len_cur) begin
      wy_nxt   = in_data.year + 14'd1;
      tord_nxt = 11'(thu - len_cur);
    end else begin
      wy_nxt   = in_data.year;
      tord_nxt = 11'(thu);
    end
    prod_w = (tord7_r - 9'd1) * DIV7_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en7) v7_r <= in_valid;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en7 && in_valid) begin
      wy7_r   <= wy_nxt;
      tord7_r <= tord_nxt[8:0];
    end
    if (en8 && v7_r) begin
      o8_r.week_year   <= wy7_r;
      o8_r.week_number <= prod_w[21:16] + 6'd1;
    end
  end

  assign out_valid = v8_r;
  assign out_data  = o8_r;

endmodule

// ===== sv/iso_week_of_date.sv =====
// Channel | Ports                          | Payload
// input   | in_valid, in_ready, in_data    | date_in_t: calendar year, month, day
// result  | out_valid, out_ready, out_data | week_out_t: week year, week number
//
// Eight register stages; one transaction enters per cycle while in_ready is high.
// The reciprocal multiplies for divide-by-100 and divide-by-7 set the stage split.
// Synchronous active-low reset empties every stage; payload registers keep no reset.
// Each stage holds while its successor is full and stalled; bubbles close up.
module iso_week_of_date import iwd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  date_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output week_out_t out_data
);

  logic     yr_valid, yr_ready;
  yr_info_t yr_data;
  logic     wd_valid, wd_ready;
  wd_info_t wd_data;

  iwd_year u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (yr_valid),
    .out_ready (yr_ready),
    .out_data  (yr_data)
  );

  iwd_wday u_wday (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yr_valid),
    .in_ready  (yr_ready),
    .in_data   (yr_data),
    .out_valid (wd_valid),
    .out_ready (wd_ready),
    .out_data  (wd_data)
  );

  iwd_week u_week (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wd_valid),
    .in_ready  (wd_ready),
    .in_data   (wd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
